// ===== rtl/mit_command_frame_encoder_defines.svh =====
// Assertion macros shared by the command frame encoder RTL.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef MIT_COMMAND_FRAME_ENCODER_DEFINES_SVH
`define MIT_COMMAND_FRAME_ENCODER_DEFINES_SVH

// Check that is switched off while reset is asserted.
`define MCFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs during reset.
`define MCFE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mcfe_pkg.sv =====
// Package for the command frame encoder: widths, lane indexes, fixed ranges and types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mcfe_pkg;

    localparam int LANES     = 5;
    localparam int IN_W      = 32;
    localparam int LIM_W     = 30;
    localparam int ID_W      = 11;
    localparam int DEN_W     = LIM_W + 1;
    localparam int QUO_W     = 16;
    localparam int NARROW_W  = 12;
    localparam int NUM_W     = DEN_W + QUO_W;
    localparam int CFG_IDX_W = 2;
    localparam int IN_TDATA_W  = LANES * IN_W;
    localparam int OUT_TDATA_W = 80;

    localparam int LANE_POS = 0;
    localparam int LANE_VEL = 1;
    localparam int LANE_KP  = 2;
    localparam int LANE_KD  = 3;
    localparam int LANE_TFF = 4;

    // Stiffness 0..500 and damping 0..5 in Q16.16.
    localparam logic [DEN_W-1:0] STIFF_SPAN = DEN_W'(32768000);
    localparam logic [DEN_W-1:0] DAMP_SPAN  = DEN_W'(327680);

    localparam logic [ID_W-1:0]  COMMAND_ID_RST     = ID_W'(1);
    localparam logic [LIM_W-1:0] POSITION_LIMIT_RST = LIM_W'(819200);
    localparam logic [LIM_W-1:0] VELOCITY_LIMIT_RST = LIM_W'(3276800);
    localparam logic [LIM_W-1:0] TORQUE_LIMIT_RST   = LIM_W'(327680);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMMAND_ID     = 2'd0,
        REG_POSITION_LIMIT = 2'd1,
        REG_VELOCITY_LIMIT = 2'd2,
        REG_TORQUE_LIMIT   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [ID_W-1:0]  command_id;
        logic [LIM_W-1:0] position_limit;
        logic [LIM_W-1:0] velocity_limit;
        logic [LIM_W-1:0] torque_limit;
    } cfg_t;

    typedef logic [LANES-1:0][DEN_W-1:0] den_vec_t;
    typedef logic [LANES-1:0][LIM_W-1:0] off_vec_t;
    typedef logic [LANES-1:0][IN_W-1:0]  in_vec_t;

    // Partial remainder and a shift word that feeds numerator bits out at the top
    // and collects quotient bits at the bottom.
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] shq;
    } div_lane_t;

    typedef struct packed {
        logic [LANES-1:0]            zero;
        div_lane_t [LANES-1:0]       lane;
    } div_word_t;

endpackage

`default_nettype wire

// ===== rtl/mcfe_cfg_regs.sv =====
// Configuration register file of the command frame encoder.
// Depends on mcfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcfe_cfg_regs
    import mcfe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LIM_W-1:0]     cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COMMAND_ID:     cfg_next.command_id     = cfg_data[ID_W-1:0];
                REG_POSITION_LIMIT: cfg_next.position_limit = cfg_data;
                REG_VELOCITY_LIMIT: cfg_next.velocity_limit = cfg_data;
                REG_TORQUE_LIMIT:   cfg_next.torque_limit   = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.command_id     <= COMMAND_ID_RST;
            cfg_reg.position_limit <= POSITION_LIMIT_RST;
            cfg_reg.velocity_limit <= VELOCITY_LIMIT_RST;
            cfg_reg.torque_limit   <= TORQUE_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mcfe_front.sv =====
// Front end of the quantizer: offset add, saturation and scaling by 2^b - 1.
// Three register stages over all five lanes; depends on mcfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcfe_front
    import mcfe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_vec_t  x,
    input  wire off_vec_t offset,
    input  wire den_vec_t span,
    output logic          out_valid,
    input  wire logic     out_ready,
    output div_word_t     out_word
);

    logic [2:0] valid_reg;
    logic [2:0] stage_ready;

    logic [LANES-1:0][IN_W:0]    sum_reg, sum_next;
    logic [LANES-1:0]            zero1_reg, zero1_next;
    logic [LANES-1:0][DEN_W-1:0] d_reg, d_next;
    logic [LANES-1:0]            zero2_reg;
    div_word_t                   word_reg, word_next;

    logic [LANES-1:0][NUM_W-1:0] num;

    assign stage_ready[2] = !valid_reg[2] || out_ready;
    assign stage_ready[1] = !valid_reg[1] || stage_ready[2];
    assign stage_ready[0] = !valid_reg[0] || stage_ready[1];
    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[2];
    assign out_word  = word_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            // Value minus the low end of its range, which is -limit or zero.
            sum_next[i]   = IN_W'(0) + ($signed({x[i][IN_W-1], x[i]})
                          + $signed({{(IN_W-LIM_W+1){1'b0}}, offset[i]}));
            zero1_next[i] = (span[i] == '0);

            if (sum_reg[i][IN_W])
                d_next[i] = '0;
            else if (sum_reg[i][IN_W-1:0] > {1'b0, span[i]})
                d_next[i] = span[i];
            else
                d_next[i] = sum_reg[i][DEN_W-1:0];

            // Multiply by 2^b - 1 as a shift and a subtract.
            if (i == LANE_POS)
                num[i] = {d_reg[i], {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, d_reg[i]};
            else
                num[i] = {{(QUO_W-NARROW_W){1'b0}}, d_reg[i], {NARROW_W{1'b0}}}
                       - {{QUO_W{1'b0}}, d_reg[i]};

            word_next.lane[i].rem = num[i][NUM_W-1:QUO_W];
            word_next.lane[i].shq = num[i][QUO_W-1:0];
        end
        word_next.zero = zero2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
                valid_reg[0] <= in_valid;
            if (stage_ready[1])
                valid_reg[1] <= valid_reg[0];
            if (stage_ready[2])
                valid_reg[2] <= valid_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            sum_reg   <= sum_next;
            zero1_reg <= zero1_next;
        end
        if (stage_ready[1])
        begin
            d_reg     <= d_next;
            zero2_reg <= zero1_reg;
        end
        if (stage_ready[2])
            word_reg <= word_next;
    end

endmodule

`default_nettype wire

// ===== rtl/mcfe_div_step.sv =====
// One restoring division step for all lanes: one quotient bit per lane per stage.
// Depends on mcfe_pkg; instantiated once per quotient bit by the top level.
`timescale 1ns / 1ps
`default_nettype none

module mcfe_div_step
    import mcfe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire den_vec_t  den,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire div_word_t in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output div_word_t      out_word
);

    logic      valid_reg;
    div_word_t word_reg, word_next;
    logic [LANES-1:0][DEN_W:0] trial;
    logic [LANES-1:0][DEN_W:0] diff;
    logic [LANES-1:0]          qbit;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        word_next.zero = in_word.zero;
        for (int i = 0; i < LANES; i++)
        begin
            // The remainder stays below the divisor, so the shifted trial fits.
            trial[i] = {in_word.lane[i].rem, in_word.lane[i].shq[QUO_W-1]};
            diff[i]  = trial[i] - {1'b0, den[i]};
            qbit[i]  = (trial[i] >= {1'b0, den[i]});
            word_next.lane[i].rem = qbit[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
            word_next.lane[i].shq = {in_word.lane[i].shq[QUO_W-2:0], qbit[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            word_reg <= word_next;
    end

endmodule

`default_nettype wire

// ===== rtl/mcfe_pack.sv =====
// Output stage: zero-range forcing, big-endian nibble packing and the output register.
// Depends on mcfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcfe_pack
    import mcfe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [ID_W-1:0]        command_id,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire div_word_t              in_word,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    logic                   valid_reg;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;
    logic [LANES-1:0][QUO_W-1:0] code;

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            code[i] = in_word.zero[i] ? '0 : in_word.lane[i].shq;

        data_next = {
            5'b0,
            code[LANE_TFF][7:0],
            code[LANE_KD][3:0], code[LANE_TFF][11:8],
            code[LANE_KD][11:4],
            code[LANE_KP][7:0],
            code[LANE_VEL][3:0], code[LANE_KP][11:8],
            code[LANE_VEL][11:4],
            code[LANE_POS][7:0],
            code[LANE_POS][15:8],
            command_id
        };
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== rtl/mit_command_frame_encoder.sv =====
// Channel   | Direction | Beat contents
// s_axis    | in        | s_tdata: five Q16.16 command values, 160 bits
// m_axis    | out       | m_tdata: CAN identifier and eight payload bytes, 80 bits
// cfg       | in        | cfg_index selects a register, cfg_data carries the value
//
// Pipeline: three front stages, sixteen restoring divider stages and the output register.
// One beat is accepted per cycle while m_tready does not stall the pipeline.
// Every stage has its own valid bit and takes a new beat whenever it is empty or draining.
// Reset clears all valid bits and loads the default identifier and limits.
// Configuration writes are always accepted; the divider stages read the live spans.
//
// Top level of the impedance command frame encoder.
// Depends on mcfe_pkg, mcfe_cfg_regs, mcfe_front, mcfe_div_step, mcfe_pack and the defines.
`timescale 1ns / 1ps
`default_nettype none
`include "mit_command_frame_encoder_defines.svh"

module mit_command_frame_encoder
    import mcfe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // target_position [31:0], target_velocity [63:32], stiffness_gain [95:64],
    // damping_gain [127:96], torque_feedforward [159:128]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // frame_id [10:0], byte0 [18:11], byte1 [26:19], byte2 [34:27], byte3 [42:35],
    // byte4 [50:43], byte5 [58:51], byte6 [66:59], byte7 [74:67], zero [79:75]
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [LIM_W-1:0]       cfg_data
);

    cfg_t     cfg;
    in_vec_t  x;
    off_vec_t offset;
    den_vec_t span;

    logic      [QUO_W:0] stg_valid;
    logic      [QUO_W:0] stg_ready;
    div_word_t [QUO_W:0] stg_word;

    mcfe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            x[i] = s_tdata[i*IN_W +: IN_W];

        offset[LANE_POS] = cfg.position_limit;
        offset[LANE_VEL] = cfg.velocity_limit;
        offset[LANE_KP]  = '0;
        offset[LANE_KD]  = '0;
        offset[LANE_TFF] = cfg.torque_limit;

        // The symmetric ranges span twice the limit.
        span[LANE_POS] = {cfg.position_limit, 1'b0};
        span[LANE_VEL] = {cfg.velocity_limit, 1'b0};
        span[LANE_KP]  = STIFF_SPAN;
        span[LANE_KD]  = DAMP_SPAN;
        span[LANE_TFF] = {cfg.torque_limit, 1'b0};
    end

    mcfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x         (x),
        .offset    (offset),
        .span      (span),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_word  (stg_word[0])
    );

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_div
        mcfe_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .den       (span),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_word   (stg_word[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_word  (stg_word[g+1])
        );
    end

    mcfe_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .command_id (cfg.command_id),
        .in_valid   (stg_valid[QUO_W]),
        .in_ready   (stg_ready[QUO_W]),
        .in_word    (stg_word[QUO_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Gain ranges are fixed, so their 12-bit codes never reach the upper quotient bits.
    `MCFE_ASSERT(a_kp_code_narrow,
        stg_valid[QUO_W] |-> (stg_word[QUO_W].lane[LANE_KP].shq[QUO_W-1:NARROW_W] == '0),
        "stiffness code exceeds 12 bits")
    `MCFE_ASSERT(a_kd_code_narrow,
        stg_valid[QUO_W] |-> (stg_word[QUO_W].lane[LANE_KD].shq[QUO_W-1:NARROW_W] == '0),
        "damping code exceeds 12 bits")
    `MCFE_ASSERT(a_in_ready_when_empty,
        !u_front.valid_reg[0] |-> s_tready,
        "input stalled while the first stage is empty")
    `MCFE_ASSERT_RST(a_no_output_after_reset,
        !rst_n |=> !m_tvalid,
        "output beat valid right after reset")

endmodule

`default_nettype wire
